@@ src/mdaag_pkg.sv @@
package mdaag_pkg;

    localparam logic [1:0] KIND_DECLARE = 2'd0;
    localparam logic [1:0] KIND_BOUND   = 2'd1;
    localparam logic [1:0] KIND_INDEX   = 2'd2;

    typedef struct packed {
        logic [1:0]         kind;
        logic [7:0]         array_id;
        logic signed [31:0] base_address;
        logic [15:0]        element_size;
        logic [3:0]         dim_count;
        logic [3:0]         dim_number;
        logic signed [31:0] lower_bound;
        logic signed [31:0] upper_bound;
        logic signed [31:0] index_value;
        logic               last_index;
    } mdaag_in_t;

    typedef struct packed {
        logic signed [31:0] address;
        logic [7:0]         ref_array_id;
    } mdaag_out_t;

endpackage

@@ src/multidim_array_address_generator_unit.sv @@
// busy is high while the state is not idle. A declare item with dimensions
// is taken in the idle state; one with none passes the done state. A bound
// item that does not finish a declaration only writes its bounds; an index
// item passes a read, a multiply and an end state. The bound item that ends a
// declaration walks the dimensions through the one shared 32x32 multiplier,
// multiplying each lower bound and each extent above dimension 1, with RAM
// reads in between. A result is shown for exactly one cycle on result with
// result_valid, in the cycle after the last index item ends, and cannot be
// held off. The bound buffers, the dimension counts and the coefficient
// table are RAMs with registered reads; no clearing pass is made after reset.
module multidim_array_address_generator_unit
    import mdaag_pkg::*;
#(
    parameter int MAX_ARRAYS = 256,
    parameter int MAX_DIMS   = 10
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    input  mdaag_in_t  item,
    output logic       busy,
    output logic       result_valid,
    output mdaag_out_t result
);

    localparam int ROW_WORDS = MAX_DIMS + 1;
    localparam int TDEPTH    = MAX_ARRAYS * ROW_WORDS;
    localparam int TAW       = $clog2(TDEPTH);
    localparam int IDW       = (MAX_ARRAYS > 1) ? $clog2(MAX_ARRAYS) : 1;
    localparam int BAW       = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_IX_RD, S_IX_MUL, S_IX_END,
        S_FN_RD, S_FN_CW, S_FN_CM,
        S_FN_LOOP, S_FN_EXT, S_FN_MC, S_FN_WC, S_FN_ML, S_FN_SUB, S_FN_DONE
    } state_t;

    state_t      state_reg;
    mdaag_in_t   in_reg;
    logic [31:0] pend_base_reg;
    logic [15:0] pend_size_reg;
    logic [3:0]  pend_dims_reg;
    logic [7:0]  pend_id_reg;
    logic [31:0] acc_reg;
    logic [31:0] const_reg;
    logic [31:0] coef_reg;
    logic [31:0] ext_reg;
    logic [3:0]  j_reg;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] prod;

    logic            t_we;
    logic [TAW-1:0]  t_waddr;
    logic [31:0]     t_wdata;
    logic [TAW-1:0]  t_raddr;
    logic [31:0]     t_rdata;
    logic            b_we;
    logic [BAW-1:0]  b_waddr;
    logic [BAW-1:0]  b_raddr;
    logic [31:0]     lo_rdata;
    logic [31:0]     hi_rdata;
    logic            d_we;
    logic [3:0]      d_rdata;

    logic        in_id_ok;
    logic        pend_id_ok;
    logic [TAW-1:0] in_row;
    logic [TAW-1:0] pend_row;
    logic        ix_dim_ok;

    assign in_id_ok   = 32'(in_reg.array_id) < 32'(MAX_ARRAYS);
    assign pend_id_ok = 32'(pend_id_reg) < 32'(MAX_ARRAYS);
    assign in_row     = TAW'(32'(in_reg.array_id) * ROW_WORDS);
    assign pend_row   = TAW'(32'(pend_id_reg) * ROW_WORDS);
    assign ix_dim_ok  = in_id_ok && (in_reg.dim_number != 4'd0)
        && (in_reg.dim_number <= d_rdata)
        && (32'(in_reg.dim_number) <= 32'(MAX_DIMS));

    mdaag_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p_reg(prod));

    mdaag_ram #(.WIDTH(32), .DEPTH(TDEPTH)) u_table (
        .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
        .raddr(t_raddr), .rdata(t_rdata)
    );

    mdaag_ram #(.WIDTH(4), .DEPTH(MAX_ARRAYS)) u_dims (
        .clk(clk), .we(d_we), .waddr(IDW'(pend_id_reg)), .wdata(pend_dims_reg),
        .raddr(IDW'(in_reg.array_id)), .rdata(d_rdata)
    );

    mdaag_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_lo (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_reg.lower_bound),
        .raddr(b_raddr), .rdata(lo_rdata)
    );

    mdaag_ram #(.WIDTH(32), .DEPTH(MAX_DIMS)) u_hi (
        .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(in_reg.upper_bound),
        .raddr(b_raddr), .rdata(hi_rdata)
    );

    assign busy = (state_reg != S_IDLE);

    always_comb
    begin
        mul_a   = coef_reg;
        mul_b   = lo_rdata;
        t_we    = 1'b0;
        t_waddr = pend_row;
        t_wdata = const_reg;
        t_raddr = in_row + TAW'(in_reg.dim_number);
        b_we    = 1'b0;
        b_waddr = BAW'(in_reg.dim_number - 4'd1);
        b_raddr = BAW'(j_reg - 4'd1);
        d_we    = 1'b0;
        unique case (state_reg)
            S_IX_MUL:
            begin
                mul_a = t_rdata;
                mul_b = in_reg.index_value;
                t_raddr = in_row;
            end
            S_FN_RD:
            begin
                b_we = 1'b1;
            end
            S_FN_CW:
            begin
                t_we    = pend_id_ok;
                t_waddr = pend_row + TAW'(pend_dims_reg);
                t_wdata = 32'(pend_size_reg);
            end
            S_FN_EXT:
            begin
                b_raddr = BAW'(j_reg);
            end
            S_FN_WC:
            begin
                mul_b = ext_reg;
            end
            S_FN_ML:
            begin
                t_we    = pend_id_ok;
                t_waddr = pend_row + TAW'(j_reg);
                t_wdata = prod;
            end
            S_FN_DONE:
            begin
                t_we    = pend_id_ok;
                t_waddr = pend_row;
                d_we    = pend_id_ok;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pend_base_reg <= '0;
            pend_size_reg <= '0;
            pend_dims_reg <= '0;
            pend_id_reg   <= '0;
            acc_reg       <= '0;
            result_valid  <= 1'b0;
        end
        else
        begin
            result_valid <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        in_reg <= item;
                        if (item.kind == KIND_DECLARE)
                        begin
                            pend_base_reg <= item.base_address;
                            pend_size_reg <= item.element_size;
                            pend_id_reg   <= item.array_id;
                            pend_dims_reg <= (item.dim_count > 4'(MAX_DIMS)) ?
                                4'(MAX_DIMS) : item.dim_count;
                            const_reg     <= item.base_address;
                            if (item.dim_count == 4'd0)
                            begin
                                state_reg <= S_FN_DONE;
                            end
                        end
                        else if (item.kind == KIND_BOUND)
                        begin
                            if (pend_dims_reg != 4'd0 && item.dim_number != 4'd0
                                && item.dim_number <= pend_dims_reg)
                            begin
                                state_reg <= S_FN_RD;
                            end
                        end
                        else if (item.kind == KIND_INDEX)
                        begin
                            state_reg <= S_IX_RD;
                        end
                    end
                end
                S_IX_RD:
                begin
                    state_reg <= S_IX_MUL;
                end
                S_IX_MUL:
                begin
                    state_reg <= S_IX_END;
                end
                S_IX_END:
                begin
                    logic [31:0] sum;
                    sum = acc_reg + (ix_dim_ok ? prod : 32'd0);
                    if (in_reg.last_index)
                    begin
                        result_valid        <= 1'b1;
                        result.address      <= (in_id_ok ? t_rdata : 32'd0) + sum;
                        result.ref_array_id <= in_reg.array_id;
                        acc_reg             <= '0;
                    end
                    else
                    begin
                        acc_reg <= sum;
                    end
                    state_reg <= S_IDLE;
                end
                S_FN_RD:
                begin
                    if (in_reg.dim_number == pend_dims_reg)
                    begin
                        j_reg     <= pend_dims_reg;
                        coef_reg  <= 32'(pend_size_reg);
                        const_reg <= pend_base_reg;
                        state_reg <= S_FN_CW;
                    end
                    else
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_FN_CW:
                begin
                    state_reg <= S_FN_CM;
                end
                S_FN_CM:
                begin
                    state_reg <= S_FN_SUB;
                end
                S_FN_SUB:
                begin
                    const_reg <= const_reg - prod;
                    j_reg     <= j_reg - 4'd1;
                    state_reg <= S_FN_LOOP;
                end
                S_FN_LOOP:
                begin
                    state_reg <= (j_reg == 4'd0) ? S_FN_DONE : S_FN_EXT;
                end
                S_FN_EXT:
                begin
                    state_reg <= S_FN_MC;
                end
                S_FN_MC:
                begin
                    ext_reg   <= hi_rdata - lo_rdata + 32'd1;
                    state_reg <= S_FN_WC;
                end
                S_FN_WC:
                begin
                    state_reg <= S_FN_ML;
                end
                S_FN_ML:
                begin
                    coef_reg  <= prod;
                    state_reg <= S_FN_CM;
                end
                S_FN_DONE:
                begin
                    pend_dims_reg <= '0;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result shown while still busy");

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result held more than one cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && item.kind == KIND_INDEX) |=> busy)
        else $error("index item not taken in");

endmodule

@@ src/mdaag_ram.sv @@
module mdaag_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/mdaag_mul.sv @@
module mdaag_mul (
    input  logic        clk,
    input  logic [31:0] a,
    input  logic [31:0] b,
    output logic [31:0] p_reg
);

    logic [31:0] full;

    assign full = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= full;
    end

endmodule
